[src/chained_xor_word_cipher_defines.svh]
// Assertion helpers for the word cipher checker.
`ifndef CHAINED_XOR_WORD_CIPHER_DEFINES_SVH
`define CHAINED_XOR_WORD_CIPHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CXW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CXW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/cxw_pkg.sv]
`timescale 1ns / 1ps
package cxw_pkg;

	localparam int CFG_IDX_W = 3;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_VECTOR  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HALF     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTE_COUNT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 3'd6;

	localparam logic [23:0] BYTE_COUNT_RST = 24'd1;

	typedef struct packed {
		logic                 valid;
		logic [CFG_IDX_W-1:0] index;
		logic [31:0]          data;
	} cfg_wr_t;

	// classified word handed from front to back
	typedef struct packed {
		logic [31:0] word;
		logic [3:0]  nmask;
		logic        last;
		logic        first;
	} item_t;

	typedef struct packed {
		logic [31:0] word;
		logic [3:0]  nmask;
		logic        last;
	} result_t;

	// low 'lanes' bits set, lanes in 0..4
	function automatic logic [3:0] lane_mask(input logic [2:0] lanes);
		logic [3:0] m;
		case (lanes)
			3'd0: m = 4'b0000;
			3'd1: m = 4'b0001;
			3'd2: m = 4'b0011;
			3'd3: m = 4'b0111;
			default: m = 4'b1111;
		endcase
		return m;
	endfunction

	function automatic logic [31:0] byte_wmask(input logic [3:0] nmask);
		return {{8{nmask[3]}}, {8{nmask[2]}}, {8{nmask[1]}}, {8{nmask[0]}}};
	endfunction

	function automatic logic [31:0] ror1(input logic [31:0] x);
		return {x[0], x[31:1]};
	endfunction

endpackage

[src/cxw_front.sv]
`timescale 1ns / 1ps
module cxw_front
	import cxw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_wr_t     cfg,
	input  logic        accept,
	input  logic [31:0] in_word,
	output item_t       item
);

	logic [23:0] byte_count_q;
	logic [1:0]  start_offset_q;
	logic [23:0] bytes_done_q;

	logic        first;
	logic [23:0] remaining;
	logic [2:0]  base_lanes;
	logic [2:0]  lanes;
	logic        last;
	logic [3:0]  nmask;

	always_comb begin
		first      = (bytes_done_q == 24'd0);
		remaining  = byte_count_q - bytes_done_q;
		base_lanes = 3'd4 - {1'b0, start_offset_q};
		if (first) begin
			lanes = base_lanes;
			if (remaining != 24'd0 && remaining < {21'd0, base_lanes}) begin
				lanes = remaining[2:0];
			end
			nmask = lane_mask(lanes) << start_offset_q;
		end else begin
			lanes = (remaining < 24'd4) ? remaining[2:0] : 3'd4;
			nmask = lane_mask(lanes);
		end
		last = ({21'd0, lanes} >= remaining);
	end

	assign item = '{word: in_word, nmask: nmask, last: last, first: first};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= BYTE_COUNT_RST;
			start_offset_q <= 2'd0;
			bytes_done_q   <= 24'd0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_BYTE_COUNT:   byte_count_q   <= cfg.data[23:0];
				CFG_START_OFFSET: start_offset_q <= cfg.data[1:0];
				default: ;
			endcase
			bytes_done_q <= 24'd0;
		end else if (accept) begin
			bytes_done_q <= last ? 24'd0 : bytes_done_q + {21'd0, lanes};
		end
	end

endmodule

[src/cxw_queue.sv]
`timescale 1ns / 1ps
module cxw_queue
	import cxw_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wr_item,
	output logic  full,
	input  logic  pop,
	output item_t rd_item,
	output logic  empty
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

[src/cxw_back.sv]
`timescale 1ns / 1ps
module cxw_back
	import cxw_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_wr_t cfg,
	input  logic    item_valid,
	input  item_t   item,
	output logic    item_take,
	output result_t res,
	output logic    res_empty,
	input  logic    res_pop
);

	// configuration
	logic        decrypt_q, decrypt_d;
	logic [31:0] iv_q, iv_d;
	logic [7:0]  kb_q, kb_d;
	logic [15:0] kh_q, kh_d;
	logic [31:0] kw_q, kw_d;

	// running cipher state
	logic [31:0] chain_q, slow_q, mid_q, fast_q;
	logic [6:0]  cnt_q;

	logic [6:0]  cnt_n;
	logic [31:0] slow_n, mid_n, fast_n, wmask, merged, chain_n;

	// result queue
	result_t    res_mem_q [2];
	logic       res_wr_q, res_rd_q;
	logic [1:0] res_cnt_q;
	logic       res_do_pop;

	always_comb begin
		decrypt_d = decrypt_q;
		iv_d      = iv_q;
		kb_d      = kb_q;
		kh_d      = kh_q;
		kw_d      = kw_q;
		case (cfg.index)
			CFG_DECRYPT_MODE: decrypt_d = cfg.data[0];
			CFG_INIT_VECTOR:  iv_d      = cfg.data;
			CFG_KEY_BYTE:     kb_d      = cfg.data[7:0];
			CFG_KEY_HALF:     kh_d      = cfg.data[15:0];
			CFG_KEY_WORD:     kw_d      = cfg.data;
			default: ;
		endcase
	end

	always_comb begin
		cnt_n  = item.first ? cnt_q : cnt_q + 7'd1;
		fast_n = item.first ? fast_q : ror1(fast_q);
		mid_n  = (!item.first && cnt_n[4:0] == 5'd1) ? ror1(mid_q) : mid_q;
		slow_n = (!item.first && cnt_n == 7'd1) ? ror1(slow_q) : slow_q;
		wmask  = byte_wmask(item.nmask);
		merged = (item.word & ~wmask) |
			((item.word ^ chain_q ^ slow_n ^ mid_n ^ fast_n) & wmask);
		chain_n = decrypt_q ? item.word : merged;
	end

	assign item_take  = item_valid && (res_cnt_q != 2'd2);
	assign res_empty  = (res_cnt_q == 2'd0);
	assign res_do_pop = res_pop && !res_empty;
	assign res        = res_mem_q[res_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decrypt_q <= 1'b0;
			iv_q      <= 32'd0;
			kb_q      <= 8'd0;
			kh_q      <= 16'd0;
			kw_q      <= 32'd0;
			chain_q   <= 32'd0;
			slow_q    <= 32'd0;
			mid_q     <= 32'd0;
			fast_q    <= 32'd0;
			cnt_q     <= 7'd0;
		end else if (cfg.valid) begin
			decrypt_q <= decrypt_d;
			iv_q      <= iv_d;
			kb_q      <= kb_d;
			kh_q      <= kh_d;
			kw_q      <= kw_d;
			chain_q   <= iv_d;
			slow_q    <= {4{kb_d}};
			mid_q     <= {2{kh_d}};
			fast_q    <= kw_d;
			cnt_q     <= 7'd0;
		end else if (item_take) begin
			if (item.last) begin
				chain_q <= iv_q;
				slow_q  <= {4{kb_q}};
				mid_q   <= {2{kh_q}};
				fast_q  <= kw_q;
				cnt_q   <= 7'd0;
			end else begin
				chain_q <= chain_n;
				slow_q  <= slow_n;
				mid_q   <= mid_n;
				fast_q  <= fast_n;
				cnt_q   <= cnt_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			res_mem_q[res_wr_q] <= '{word: merged, nmask: item.nmask, last: item.last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= 1'b0;
			res_rd_q  <= 1'b0;
			res_cnt_q <= 2'd0;
		end else begin
			if (item_take) begin
				res_wr_q <= !res_wr_q;
			end
			if (res_do_pop) begin
				res_rd_q <= !res_rd_q;
			end
			res_cnt_q <= res_cnt_q + {1'b0, item_take} - {1'b0, res_do_pop};
		end
	end

endmodule

[src/chained_xor_word_cipher.sv]
`timescale 1ns / 1ps
// Channel   | Handshake                | Payload
// ----------+--------------------------+---------------------------------
// source    | push / full              | in_word[31:0]
// result    | pop / empty              | out_word[31:0], byte_mask[3:0], last_word
// config    | cfg_valid / cfg_ready    | cfg_index[2:0], cfg_data[31:0]
//
// Throughput: one word per cycle whenever neither side stalls.
// A pushed word is registered in the hand-off queue (front classify), then
// in the result queue (back cipher), before it shows with empty low.
// Reset clears both queues and loads the register reset values (byte_count
// 1, all else 0); the transfer state comes up reloaded.
// A stalled result side fills the result queue, then the hand-off queue,
// then raises full. cfg_ready is always high; a write reloads the state.
module chained_xor_word_cipher
	import cxw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// source words
	input  logic                 push,
	output logic                 full,
	input  logic [31:0]          in_word,
	// results
	output logic                 empty,
	input  logic                 pop,
	output logic [31:0]          out_word,
	output logic [3:0]           byte_mask,
	output logic                 last_word,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	cfg_wr_t cfg;
	logic    accept;
	item_t   fe_item;
	item_t   be_item;
	logic    mid_full;
	logic    mid_empty;
	logic    be_take;
	result_t res;

	// config port never stalls; writes must only arrive while idle, which the block does not enforce
	assign cfg_ready = 1'b1;
	assign cfg       = '{valid: cfg_valid, index: cfg_index, data: cfg_data};

	// source transaction taken whenever the hand-off queue has room
	assign full   = mid_full;
	assign accept = push && !mid_full;

	// front: tracks bytes done, works out lane mask, first and last flags
	cxw_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.accept  (accept),
		.in_word (in_word),
		.item    (fe_item)
	);

	// two-entry hand-off between classify and cipher
	cxw_queue u_mid (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (accept),
		.wr_item (fe_item),
		.full    (mid_full),
		.pop     (be_take),
		.rd_item (be_item),
		.empty   (mid_empty)
	);

	// back: key schedule, XOR merge, chaining, result queue
	cxw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (!mid_empty),
		.item       (be_item),
		.item_take  (be_take),
		.res        (res),
		.res_empty  (empty),
		.res_pop    (pop)
	);

	assign out_word  = res.word;
	assign byte_mask = res.nmask;
	assign last_word = res.last;

endmodule

[src/cxw_checker.sv]
`timescale 1ns / 1ps
`include "chained_xor_word_cipher_defines.svh"
module cxw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [31:0] out_word,
	input logic [3:0]  byte_mask,
	input logic        last_word
);

	// every result covers at least one byte
	`CXW_ASSERT_NOW(a_mask_nonzero, clk, arst_n, !empty, byte_mask != 4'd0, "empty byte mask")

	// a word that does not end the transfer runs up to the top lane
	`CXW_ASSERT_NOW(a_mid_reaches_top, clk, arst_n, !empty && !last_word, byte_mask[3], "non-last word stops short of lane 3")

	// covered lanes are one contiguous run
	`CXW_ASSERT_NOW(a_mask_contig, clk, arst_n, !empty, !(byte_mask == 4'b0101 || byte_mask == 4'b1001 || byte_mask == 4'b1010 || byte_mask == 4'b1011 || byte_mask == 4'b1101), "byte mask has a hole")

	// a waiting result transaction holds until taken
	`CXW_ASSERT_NEXT(a_res_hold, clk, arst_n, !empty && !pop, !empty && $stable(out_word) && $stable(byte_mask) && $stable(last_word), "result changed while stalled")

endmodule

bind chained_xor_word_cipher cxw_checker u_cxw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.empty     (empty),
	.pop       (pop),
	.out_word  (out_word),
	.byte_mask (byte_mask),
	.last_word (last_word)
);

[sim/chained_xor_word_cipher_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the chained XOR word cipher.
// A source driver feeds words from a queue filled by the sequencer, a result
// monitor pops and compares every word against an in-bench cipher model.
// Config writes only happen with nothing in flight.
module chained_xor_word_cipher_tb;
	import cxw_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 6;
	localparam int ITEMS        = 1350;
	localparam int HOLD_CYCLES  = 400;   // long sink hold-off, fills the block
	localparam int LATENCY_PAD  = 4;     // drain margin after the last result
	localparam int WDOG_LIMIT   = 3000;  // cycles with no transaction at all

	// index past the register list: value dropped, state still reloaded
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 push      = 1'b0;
	logic                 full;
	logic [31:0]          in_word   = '0;
	logic                 empty;
	logic                 pop       = 1'b0;
	logic [31:0]          out_word;
	logic [3:0]           byte_mask;
	logic                 last_word;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data  = '0;

	chained_xor_word_cipher u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_word   (in_word),
		.empty     (empty),
		.pop       (pop),
		.out_word  (out_word),
		.byte_mask (byte_mask),
		.last_word (last_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	// ------------------------------------------------------------------
	// Cipher model: register copy plus running transfer state
	// ------------------------------------------------------------------
	logic        r_decrypt;
	logic [31:0] r_iv;
	logic [7:0]  r_kbyte;
	logic [15:0] r_khalf;
	logic [31:0] r_kword;
	logic [23:0] r_count;
	logic [1:0]  r_offset;

	logic [31:0] m_chain, m_slow, m_mid, m_fast;
	logic [6:0]  m_wcnt;
	logic [23:0] m_done;

	function automatic void restart_transfer();
		m_chain = r_iv;
		m_slow  = {4{r_kbyte}};
		m_mid   = {2{r_khalf}};
		m_fast  = r_kword;
		m_wcnt  = '0;
		m_done  = '0;
	endfunction

	function automatic void model_reset();
		r_decrypt = 1'b0;
		r_iv      = '0;
		r_kbyte   = '0;
		r_khalf   = '0;
		r_kword   = '0;
		r_count   = BYTE_COUNT_RST;
		r_offset  = '0;
		restart_transfer();
	endfunction

	// any write reloads the transfer state, mapped or not
	function automatic void load_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
		case (idx)
			CFG_DECRYPT_MODE: r_decrypt = d[0];
			CFG_INIT_VECTOR:  r_iv      = d;
			CFG_KEY_BYTE:     r_kbyte   = d[7:0];
			CFG_KEY_HALF:     r_khalf   = d[15:0];
			CFG_KEY_WORD:     r_kword   = d;
			CFG_BYTE_COUNT:   r_count   = d[23:0];
			CFG_START_OFFSET: r_offset  = d[1:0];
			default: ;
		endcase
		restart_transfer();
	endfunction

	// one source word in, one merged word out; advances the model
	function automatic result_t cipher_word(input logic [31:0] src);
		logic [23:0] remaining;
		logic [2:0]  lanes;
		logic [1:0]  lane0;
		logic [4:0]  low_lanes;
		logic [7:0]  lane_bits;
		logic [31:0] wmask, merged;
		logic        is_last;
		result_t     res;
		remaining = r_count - m_done;
		if (m_done == '0) begin
			// head word: from start offset up, clipped by a short count;
			// a zero count takes the whole head and closes the transfer
			lane0 = r_offset;
			lanes = 3'd4 - lane0;
			if (remaining != '0 && remaining < lanes)
				lanes = remaining[2:0];
		end else begin
			m_wcnt = m_wcnt + 7'd1;
			m_fast = {m_fast[0], m_fast[31:1]};
			if (m_wcnt[4:0] == 5'd1)
				m_mid = {m_mid[0], m_mid[31:1]};
			if (m_wcnt == 7'd1)
				m_slow = {m_slow[0], m_slow[31:1]};
			lane0 = 2'd0;
			lanes = (remaining < 24'd4) ? remaining[2:0] : 3'd4;
		end
		low_lanes = (5'd1 << lanes) - 5'd1;
		lane_bits = {3'b000, low_lanes} << lane0;
		wmask = '0;
		for (int i = 0; i < 4; i++)
			if (lane_bits[i])
				wmask[8*i +: 8] = 8'hff;
		merged = (src & ~wmask) | ((src ^ m_chain ^ m_slow ^ m_mid ^ m_fast) & wmask);
		m_chain = r_decrypt ? src : merged;
		is_last = (24'(lanes) >= remaining);
		if (is_last)
			restart_transfer();
		else
			m_done = m_done + 24'(lanes);
		res.word  = merged;
		res.nmask = lane_bits[3:0];
		res.last  = is_last;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Shared bench state
	// ------------------------------------------------------------------
	logic [31:0] src_q[$];       // words waiting for the source driver
	result_t     cipher_q[$];    // predicted results, oldest first
	bit          quiet = 1'b0;   // phase with no idling on either side
	bit          burst = 1'b0;   // source offers back to back
	bit          sink_hold_req = 1'b0;
	int          src_gap   = 0;
	int          sink_gap  = 0;
	int          sink_hold = 0;
	int          n_accepted = 0;
	int          n_checked  = 0;
	int          n_cfg      = 0;
	int          n_err      = 0;
	int          n_queued   = 0;
	int          n_phase    = 0;
	int          n_holds    = 0;
	int          idle_cycles = 0;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------
	// Source driver: one word in flight, held until push && !full
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && !(push && full)) begin
			if (src_gap != 0) begin
				src_gap--;
				push <= 1'b0;
			end else if (src_q.size() != 0) begin
				push    <= 1'b1;
				in_word <= src_q.pop_front();
				src_gap = pick_gap(quiet || burst);
			end else begin
				push <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: tracks config writes and source transactions into the
	// model, checks popped results, and paces pop. Prediction sits here
	// so queue order never depends on process order.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_mon
		result_t want;
		bit      taken;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				load_reg(cfg_index, cfg_data);
				n_cfg++;
			end
			if (push && !full) begin
				cipher_q.push_back(cipher_word(in_word));
				n_accepted++;
			end
			taken = pop && !empty;
			if (taken) begin
				if (cipher_q.size() == 0) begin
					$error("unexpected result: out_word %h byte_mask %h last_word %b",
						out_word, byte_mask, last_word);
					n_err++;
				end else begin
					want = cipher_q.pop_front();
					n_checked++;
					if (out_word !== want.word) begin
						$error("out_word: expected %h, got %h", want.word, out_word);
						n_err++;
					end
					if (byte_mask !== want.nmask) begin
						$error("byte_mask: expected %h, got %h", want.nmask, byte_mask);
						n_err++;
					end
					if (last_word !== want.last) begin
						$error("last_word: expected %b, got %b", want.last, last_word);
						n_err++;
					end
				end
			end
			// pop pacing: long hold-off first, then random gaps
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				sink_hold = HOLD_CYCLES;
				n_holds++;
				pop <= 1'b0;
			end else if (sink_hold != 0) begin
				sink_hold--;
				pop <= 1'b0;
			end else if (taken || !pop) begin
				if (taken)
					sink_gap = pick_gap(quiet);
				else if (sink_gap != 0)
					sink_gap--;
				pop <= (sink_gap == 0);
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: any stretch without a transaction on any channel
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
					WDOG_LIMIT, cipher_q.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	logic        c_dec;
	logic [31:0] c_iv;
	logic [7:0]  c_kbyte;
	logic [15:0] c_khalf;
	logic [31:0] c_kword;
	logic [23:0] c_cnt   = BYTE_COUNT_RST;
	logic [1:0]  c_off   = '0;

	// all source and result traffic drained, plus the pipeline latency
	task automatic wait_idle();
		do @(negedge clk);
		while (src_q.size() != 0 || push || cipher_q.size() != 0);
		repeat (LATENCY_PAD) @(negedge clk);
	endtask

	// one config transaction; junk above the register width is allowed
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] with_junk(input logic [31:0] v, input int width);
		return (32'($urandom) << width) | v;
	endfunction

	task automatic program_regs(input logic [6:0] which);
		if (which[0]) write_reg(CFG_DECRYPT_MODE, with_junk(32'(c_dec), 1));
		if (which[1]) write_reg(CFG_INIT_VECTOR,  c_iv);
		if (which[2]) write_reg(CFG_KEY_BYTE,     with_junk(32'(c_kbyte), 8));
		if (which[3]) write_reg(CFG_KEY_HALF,     with_junk(32'(c_khalf), 16));
		if (which[4]) write_reg(CFG_KEY_WORD,     c_kword);
		if (which[5]) write_reg(CFG_BYTE_COUNT,   with_junk(32'(c_cnt), 24));
		if (which[6]) write_reg(CFG_START_OFFSET, with_junk(32'(c_off), 2));
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// called at a falling edge so the driver never races the queue
	task automatic queue_words(input int n);
		for (int i = 0; i < n; i++)
			src_q.push_back(rand_word());
		n_queued += n;
	endtask

	task automatic queue_word(input logic [31:0] w);
		src_q.push_back(w);
		n_queued++;
	endtask

	function automatic int words_in_transfer(input int cnt, input int off);
		int head;
		if (cnt == 0)
			return 1;
		head = 4 - off;
		if (cnt <= head)
			return 1;
		return 1 + (cnt - head + 3) / 4;
	endfunction

	initial begin
		int          per, words;
		logic [6:0]  which;
		model_reset();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed ---
		// reset config: single-byte transfers in lane 0
		queue_word(32'h0000_0000);
		queue_word(32'hffff_ffff);
		wait_idle();

		// all-ones keys and IV, head word only lane 3, short tail
		c_dec = 1'b0; c_iv = '1; c_kbyte = '1; c_khalf = '1; c_kword = '1;
		c_cnt = 24'd7; c_off = 2'd3;
		program_regs(7'h7f);
		queue_word(32'h1234_5678);
		queue_word(32'hffff_ffff);
		queue_word(32'h0000_0000);
		wait_idle();

		// decrypt, zero byte count: each word closes its own transfer
		c_dec = 1'b1; c_iv = '0; c_kbyte = 8'ha5; c_khalf = 16'h1234;
		c_kword = 32'h8000_0001; c_cnt = 24'd0; c_off = 2'd1;
		program_regs(7'h7f);
		queue_word(32'hdead_beef);
		queue_word(32'h0f0f_0f0f);
		wait_idle();

		// count smaller than the head lanes
		c_cnt = 24'd2;
		program_regs(7'h20);
		queue_word(32'haaaa_5555);
		queue_word(32'h5555_aaaa);
		wait_idle();

		// maximum count, then abort mid-transfer with an unmapped write
		c_dec = 1'b0; c_cnt = 24'hff_ffff; c_off = 2'd0;
		program_regs(7'h61);
		queue_words(10);
		wait_idle();
		write_reg(CFG_UNMAPPED, $urandom);
		@(negedge clk);
		queue_words(3);
		wait_idle();

		// odd offset and count straddling words
		c_cnt = 24'd5; c_off = 2'd2;
		program_regs(7'h60);
		queue_words(4);

		// --- random phases ---
		while (n_queued < ITEMS) begin
			wait_idle();
			n_phase++;
			quiet = ($urandom_range(0, 4) == 0);
			burst = 1'b0;
			which = 7'($urandom);
			if (which == '0)
				which = 7'(1 << $urandom_range(0, 6));
			if (which[0]) c_dec = 1'($urandom);
			if (which[1]) c_iv = ($urandom_range(0, 7) == 0) ? '1 : $urandom;
			if (which[2]) c_kbyte = 8'($urandom);
			if (which[3]) c_khalf = 16'($urandom);
			if (which[4]) c_kword = ($urandom_range(0, 7) == 0) ? '0 : $urandom;
			if (which[5]) begin
				case ($urandom_range(0, 15))
					0:       c_cnt = 24'd0;
					1:       c_cnt = 24'hff_ffff;
					2:       c_cnt = 24'($urandom_range(500, 700));  // slow key wraps
					3:       c_cnt = 24'($urandom_range(41, 200));
					default: c_cnt = 24'($urandom_range(1, 40));
				endcase
			end
			if (which[6]) c_off = 2'($urandom);
			program_regs(which);
			if ($urandom_range(0, 9) == 0) begin
				write_reg(CFG_UNMAPPED, $urandom);
				@(negedge clk);
			end

			if (c_cnt == 24'hff_ffff) begin
				words = $urandom_range(3, 30);
			end else begin
				per = words_in_transfer(int'(c_cnt), int'(c_off));
				words = per * ((per > 100) ? 1 : $urandom_range(1, 3));
				// broken tail: partial transfer, aborted by the next write
				if ($urandom_range(0, 4) == 0)
					words += $urandom_range(0, per - 1);
			end

			// sink stalls long while the source keeps offering
			if (n_phase == 1 || $urandom_range(0, 29) == 0) begin
				burst = 1'b1;
				sink_hold_req = 1'b1;
				words += 60;
			end
			queue_words(words);
		end

		wait_idle();
		repeat (10) @(negedge clk);
		if (cipher_q.size() != 0) begin
			$error("%0d expected results never arrived", cipher_q.size());
			n_err++;
		end

		$display("Covered %0d source words over %0d random phases, %0d config writes, %0d sink hold-offs.",
			n_accepted, n_phase, n_cfg, n_holds);
		$display("Compared %0d result words, %0d field mismatches.", n_checked, n_err);
		if (n_err == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
